// ===== sv/whnm_pkg.sv =====
package whnm_pkg;

	// field and state widths
	localparam int IDX_W    = 12;
	localparam int DIST_W   = 10;
	localparam int HEIGHT_W = 12;
	localparam int POS_W    = 16;
	localparam int RAD_W    = 8;
	localparam int WORD_W   = 64;
	localparam int PC_W     = 7;

	// descriptor organization
	localparam int NWORDS     = 8;
	localparam int DESC_WORDS = 8;

	// item kinds
	localparam logic [1:0] KIND_QUERY = 2'd0;
	localparam logic [1:0] KIND_CAND  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// register indexes
	localparam logic REG_MAX_DIST   = 1'b0;
	localparam logic REG_IMG_HEIGHT = 1'b1;

	// reset values
	localparam logic [DIST_W-1:0]   RST_MAX_DIST   = 10'd50;
	localparam logic [HEIGHT_W-1:0] RST_IMG_HEIGHT = 12'd480;
	localparam logic [DIST_W-1:0]   DIST_SAT       = {DIST_W{1'b1}};
	localparam logic [DIST_W-1:0]   BEST_RESET     = RST_MAX_DIST + 10'd1;

	// starting best distance for a new query, saturated
	function automatic logic [DIST_W-1:0] init_best(input logic [DIST_W-1:0] maxd);
		logic [DIST_W:0] b;
		b = {1'b0, maxd} + {{DIST_W{1'b0}}, 1'b1};
		return b[DIST_W] ? DIST_SAT : b[DIST_W-1:0];
	endfunction

endpackage

// ===== sv/whnm_popcount64.sv =====
module whnm_popcount64 (
	input  logic [whnm_pkg::WORD_W-1:0] word,
	output logic [whnm_pkg::PC_W-1:0]   count
);

	logic [1:0] l1 [32];
	logic [2:0] l2 [16];
	logic [3:0] l3 [8];
	logic [4:0] l4 [4];
	logic [5:0] l5 [2];

	// balanced adder tree over bit pairs
	always_comb begin
		for (int i = 0; i < 32; i++) begin
			l1[i] = {1'b0, word[2*i]} + {1'b0, word[2*i+1]};
		end
		for (int i = 0; i < 16; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
		end
		count = {1'b0, l5[0]} + {1'b0, l5[1]};
	end

endmodule

// ===== sv/windowed_hamming_nearest_match_unit.sv =====
// Nearest-match search over a stream of 512-bit binary descriptors. A query
// item loads the search point, descriptor and radius and restarts the search;
// candidate items are numbered from 0 and compared against the query when they
// fall inside the row, column and circle window; an end item delivers found,
// match_index and best_distance. The block takes one item every clock cycle
// while not stalled. Each item passes three register stages (input, window
// and popcount, distance sum and circle test) before the running minimum; an
// end item's result then goes to the output register. The input stalls
// only while a result waits unclaimed in the output register and a second end
// item has reached the running-minimum stage behind it. Registers are written
// through the APB port: max_distance at byte address 0, image_height at 4.
module windowed_hamming_nearest_match_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [7:0]  search_radius,
	input  logic [63:0] desc_word_0,
	input  logic [63:0] desc_word_1,
	input  logic [63:0] desc_word_2,
	input  logic [63:0] desc_word_3,
	input  logic [63:0] desc_word_4,
	input  logic [63:0] desc_word_5,
	input  logic [63:0] desc_word_6,
	input  logic [63:0] desc_word_7,

	output logic        result_valid,
	input  logic        result_stall,
	output logic        found,
	output logic [11:0] match_index,
	output logic [9:0]  best_distance
);

	localparam int NW  = whnm_pkg::NWORDS;
	localparam int WW  = whnm_pkg::WORD_W;
	localparam int PW  = whnm_pkg::PC_W;
	localparam int DW  = whnm_pkg::DIST_W;
	localparam int IW  = whnm_pkg::IDX_W;
	localparam int HW  = whnm_pkg::HEIGHT_W;
	localparam int XW  = whnm_pkg::POS_W;
	localparam int RW  = whnm_pkg::RAD_W;
	localparam int CW  = XW - 4;

	// configuration registers
	logic [DW-1:0] max_dist_q;
	logic [HW-1:0] img_height_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q   <= whnm_pkg::RST_MAX_DIST;
			img_height_q <= whnm_pkg::RST_IMG_HEIGHT;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				whnm_pkg::REG_MAX_DIST:   max_dist_q   <= pwdata[DW-1:0];
				whnm_pkg::REG_IMG_HEIGHT: img_height_q <= pwdata[HW-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[2])
			whnm_pkg::REG_MAX_DIST:   prdata = {{(32-DW){1'b0}}, max_dist_q};
			whnm_pkg::REG_IMG_HEIGHT: prdata = {{(32-HW){1'b0}}, img_height_q};
			default:                  prdata = '0;
		endcase
	end

	// pipeline advance: only a waiting result blocks a second end request
	logic adv;
	logic v_s1, v_s2, v_s3;
	logic [1:0] kind_s3;
	logic out_valid_q;

	assign adv        = !(v_s3 && (kind_s3 == whnm_pkg::KIND_END) && out_valid_q && result_stall);
	assign item_stall = !adv;

	logic [WW-1:0] desc_in [NW];
	assign desc_in[0] = desc_word_0;
	assign desc_in[1] = desc_word_1;
	assign desc_in[2] = desc_word_2;
	assign desc_in[3] = desc_word_3;
	assign desc_in[4] = desc_word_4;
	assign desc_in[5] = desc_word_5;
	assign desc_in[6] = desc_word_6;
	assign desc_in[7] = desc_word_7;

	// stage 1: input register
	logic [1:0]    kind_s1;
	logic [XW-1:0] px_s1, py_s1;
	logic [RW-1:0] rad_s1;
	logic [WW-1:0] desc_s1 [NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			px_s1   <= pos_x;
			py_s1   <= pos_y;
			rad_s1  <= search_radius;
			for (int i = 0; i < NW; i++) begin
				desc_s1[i] <= desc_in[i];
			end
		end
	end

	// query state and candidate numbering
	logic [XW-1:0] qx_q, qy_q;
	logic [RW-1:0] qrad_q;
	logic [WW-1:0] qdesc_q [NW];
	logic [IW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q    <= '0;
			qy_q    <= '0;
			qrad_q  <= '0;
			count_q <= '0;
			for (int i = 0; i < NW; i++) begin
				qdesc_q[i] <= '0;
			end
		end else if (adv && v_s1) begin
			if (kind_s1 == whnm_pkg::KIND_QUERY) begin
				qx_q    <= px_s1;
				qy_q    <= py_s1;
				qrad_q  <= rad_s1;
				count_q <= '0;
				for (int i = 0; i < NW; i++) begin
					qdesc_q[i] <= desc_s1[i];
				end
			end else if (kind_s1 == whnm_pkg::KIND_CAND) begin
				count_q <= count_q + {{(IW-1){1'b0}}, 1'b1};
			end
		end
	end

	// row and column window against the current query
	logic [CW-1:0] row, qr, qc;
	logic          row_ok, col_ok;
	logic [XW-1:0] dx, dy;
	logic [2*XW-1:0] dx2, dy2;
	logic [2*RW-1:0] r2;

	assign row = py_s1[XW-1:4];
	assign qr  = qy_q[XW-1:4];
	assign qc  = qx_q[XW-1:4];

	always_comb begin
		row_ok = (({1'b0, row} + {{(CW+1-RW){1'b0}}, qrad_q}) >= {1'b0, qr}) &&
		         ({1'b0, row} <= ({1'b0, qr} + {{(CW+1-RW){1'b0}}, qrad_q})) &&
		         (row < img_height_q);
		col_ok = (({1'b0, px_s1} + {{(XW-3-RW){1'b0}}, qrad_q, 4'b0}) >= {1'b0, qc, 4'b0}) &&
		         ({1'b0, px_s1} <= {({1'b0, qc} + {{(CW+1-RW){1'b0}}, qrad_q}), 4'b0});
		dx  = (px_s1 >= qx_q) ? (px_s1 - qx_q) : (qx_q - px_s1);
		dy  = (py_s1 >= qy_q) ? (py_s1 - qy_q) : (qy_q - py_s1);
		dx2 = dx * dx;
		dy2 = dy * dy;
		r2  = qrad_q * qrad_q;
	end

	// per-word hamming counts
	logic [PW-1:0] pc [NW];

	for (genvar g = 0; g < NW; g++) begin : g_pc
		logic [PW-1:0] cnt;
		whnm_popcount64 u_pc (
			.word  (desc_s1[g] ^ qdesc_q[g]),
			.count (cnt)
		);
		if (g < whnm_pkg::DESC_WORDS) begin : g_use
			assign pc[g] = cnt;
		end else begin : g_skip
			assign pc[g] = '0;
		end
	end

	// stage 2: window flags, squares and word counts
	logic [1:0]      kind_s2;
	logic [IW-1:0]   idx_s2;
	logic            win_s2;
	logic [2*XW-1:0] dx2_s2, dy2_s2;
	logic [2*RW-1:0] r2_s2;
	logic [PW-1:0]   pc_s2 [NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			idx_s2  <= count_q;
			win_s2  <= row_ok && col_ok;
			dx2_s2  <= dx2;
			dy2_s2  <= dy2;
			r2_s2   <= r2;
			for (int i = 0; i < NW; i++) begin
				pc_s2[i] <= pc[i];
			end
		end
	end

	// circle test and total distance
	logic [2*XW:0] d2;
	logic          circ_ok;
	logic [DW-1:0] dist_sum;

	always_comb begin
		d2       = {1'b0, dx2_s2} + {1'b0, dy2_s2};
		circ_ok  = d2 <= {{(2*XW+1-2*RW-8){1'b0}}, r2_s2, 8'b0};
		dist_sum = '0;
		for (int i = 0; i < NW; i++) begin
			dist_sum = dist_sum + {{(DW-PW){1'b0}}, pc_s2[i]};
		end
	end

	// stage 3: considered flag and distance
	logic [IW-1:0] idx_s3;
	logic          hit_s3;
	logic [DW-1:0] dist_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3 <= kind_s2;
			idx_s3  <= idx_s2;
			hit_s3  <= win_s2 && circ_ok;
			dist_s3 <= dist_sum;
		end
	end

	// running minimum
	logic [DW-1:0] best_q;
	logic [IW-1:0] bpos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= whnm_pkg::BEST_RESET;
			bpos_q <= '0;
		end else if (adv && v_s3) begin
			if (kind_s3 == whnm_pkg::KIND_QUERY) begin
				best_q <= whnm_pkg::init_best(max_dist_q);
				bpos_q <= '0;
			end else if ((kind_s3 == whnm_pkg::KIND_CAND) && hit_s3 && (dist_s3 < best_q)) begin
				best_q <= dist_s3;
				bpos_q <= idx_s3;
			end
		end
	end

	// result register
	logic          end_ret;
	logic          found_q;
	logic [IW-1:0] mi_q;
	logic [DW-1:0] bd_q;

	assign end_ret = adv && v_s3 && (kind_s3 == whnm_pkg::KIND_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (end_ret) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_ret) begin
			found_q <= best_q < max_dist_q;
			mi_q    <= bpos_q;
			bd_q    <= best_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign found         = found_q;
	assign match_index   = mi_q;
	assign best_distance = bd_q;

endmodule

// ===== sv/whnm_checker.sv =====
module whnm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic        found,
	input logic [11:0] match_index,
	input logic [9:0]  best_distance
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(found) && $stable(match_index) && $stable(best_distance))
		else $error("stalled result changed");

	// the input backs up only behind an unclaimed result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled with output free");

	// no result during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind windowed_hamming_nearest_match_unit whnm_checker u_whnm_checker (.*);
